// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/rmbv_pkg.sv =====
package rmbv_pkg;

    localparam int CW   = 16;   // input component width
    localparam int RW   = 15;   // component width after range reduction
    localparam int NW   = 30;   // squared norm
    localparam int XW   = 60;   // product of the two squared norms
    localparam int RTW  = 30;   // integer square root
    localparam int DW   = 31;   // dot product and cross product components
    localparam int CCW  = 60;   // products of cross components
    localparam int PDW  = 32;   // P + d
    localparam int QW   = 61;   // divisor P * (P + d)
    localparam int SW   = 63;   // signed numerator of one entry
    localparam int OW   = 16;   // output entry
    localparam int NE   = 9;    // matrix entries
    localparam int NCC  = 6;    // distinct cross products c_i * c_j

    localparam int FRAC_DEFAULT = 14;

    typedef struct packed {
        logic signed [CW-1:0] before_x;
        logic signed [CW-1:0] before_y;
        logic signed [CW-1:0] before_z;
        logic signed [CW-1:0] after_x;
        logic signed [CW-1:0] after_y;
        logic signed [CW-1:0] after_z;
    } t_in;

    typedef struct packed {
        logic signed [OW-1:0] m00;
        logic signed [OW-1:0] m01;
        logic signed [OW-1:0] m02;
        logic signed [OW-1:0] m10;
        logic signed [OW-1:0] m11;
        logic signed [OW-1:0] m12;
        logic signed [OW-1:0] m20;
        logic signed [OW-1:0] m21;
        logic signed [OW-1:0] m22;
        logic                 degenerate;
    } t_out;

    // Data that travels alongside the square root pipeline.
    typedef struct packed {
        logic                      zero;
        logic [DW-1:0]             d;
        logic [2:0][DW-1:0]        c;
        logic [NCC-1:0][CCW-1:0]   cc;
    } t_sq_side;

    // Data that travels alongside the divider pipeline.
    typedef struct packed {
        logic          dg;
        logic [NE-1:0] neg;
    } t_dv_side;

endpackage

// ===== sv/rmbv_sqrt.sv =====
module rmbv_sqrt import rmbv_pkg::*; #(
    parameter int SBW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [XW-1:0]     i_x,
    input  logic [SBW-1:0]    i_side,
    output logic              o_valid,
    output logic [RTW-1:0]    o_root,
    output logic [SBW-1:0]    o_side
);

    localparam int XW1 = XW + 1;

    logic              r_v    [RTW];
    logic [XW-1:0]     r_rem  [RTW];
    logic [RTW-1:0]    r_root [RTW];
    logic [SBW-1:0]    r_side [RTW];

    // One result bit per stage, most significant first.
    for (genvar k = 0; k < RTW; k++) begin : g_step
        localparam int B = RTW - 1 - k;

        logic           v_in;
        logic [XW-1:0]  rem_in;
        logic [RTW-1:0] root_in;
        logic [SBW-1:0] side_in;
        logic [XW1-1:0] trial;
        logic [XW-1:0]  n_rem;
        logic [RTW-1:0] n_root;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = i_x;
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign side_in = r_side[k-1];
        end

        always_comb begin
            trial  = (XW1'(root_in) << (B + 1)) + (XW1'(1) << (2 * B));
            n_rem  = rem_in;
            n_root = root_in;
            if ({1'b0, rem_in} >= trial) begin
                n_rem  = XW'({1'b0, rem_in} - trial);
                n_root = root_in | (RTW'(1) << B);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[RTW-1];
    assign o_root  = r_root[RTW-1];
    assign o_side  = r_side[RTW-1];

endmodule

// ===== sv/rmbv_div.sv =====
module rmbv_div import rmbv_pkg::*; #(
    parameter int FRAC = FRAC_DEFAULT,
    parameter int SBW  = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [SW+FRAC-1:0]      i_num [NE],
    input  logic [QW-1:0]           i_q,
    input  logic [SBW-1:0]          i_side,
    output logic                    o_valid,
    output logic [FRAC+1:0]         o_quo [NE],
    output logic                    o_big [NE],
    output logic [SBW-1:0]          o_side
);

    localparam int DVW = SW + FRAC;
    localparam int QB  = FRAC + 2;

    // Stage 0 checks for overflow; stages 1..QB each produce one quotient bit.
    logic              r_v    [QB+1];
    logic [QW-1:0]     r_q    [QB+1];
    logic [SBW-1:0]    r_side [QB+1];
    logic [QW-1:0]     r_rem  [QB+1][NE];
    logic [QB-1:0]     r_lo   [QB+1][NE];
    logic [QB-1:0]     r_quo  [QB+1][NE];
    logic              r_big  [QB+1][NE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0]    <= i_q;
            r_side[0] <= i_side;
            for (int l = 0; l < NE; l++) begin
                r_rem[0][l] <= i_num[l][DVW-1:QB];
                r_lo[0][l]  <= i_num[l][QB-1:0];
                r_quo[0][l] <= '0;
                r_big[0][l] <= (i_num[l][DVW-1:QB] >= i_q);
            end
        end
    end

    for (genvar s = 1; s <= QB; s++) begin : g_step
        localparam int BI = QB - s;

        logic [QW:0]   rem2  [NE];
        logic          ge    [NE];
        logic [QW-1:0] n_rem [NE];

        always_comb begin
            for (int l = 0; l < NE; l++) begin
                rem2[l]  = {r_rem[s-1][l], r_lo[s-1][l][BI]};
                ge[l]    = (rem2[l] >= {1'b0, r_q[s-1]});
                n_rem[l] = ge[l] ? QW'(rem2[l] - {1'b0, r_q[s-1]}) : QW'(rem2[l]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= r_v[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[s]    <= r_q[s-1];
                r_side[s] <= r_side[s-1];
                for (int l = 0; l < NE; l++) begin
                    r_rem[s][l] <= n_rem[l];
                    r_lo[s][l]  <= r_lo[s-1][l];
                    r_quo[s][l] <= {r_quo[s-1][l][QB-2:0], ge[l]};
                    r_big[s][l] <= r_big[s-1][l];
                end
            end
        end
    end

    assign o_valid = r_v[QB];
    assign o_side  = r_side[QB];

    always_comb begin
        for (int l = 0; l < NE; l++) begin
            o_quo[l] = r_quo[QB][l];
            o_big[l] = r_big[QB][l];
        end
    end

endmodule

// ===== sv/rotation_matrix_between_vectors.sv =====
// Rotation matrix between two vectors, Rodrigues form, in fixed point.
//
// Input channel: i_valid / o_stall carry one transaction of two signed
// 3-vectors (before, after) in i_data. Output channel: o_valid / i_stall
// carry the 3x3 matrix that turns the first direction onto the second, in
// Q(16-FRACTION_BITS).FRACTION_BITS, plus the degenerate flag in o_data.
// A transaction moves at a rising edge where valid is high and stall is low.
//
// Throughput is one transaction per cycle while o_stall is low. From
// acceptance to o_valid a transaction passes through four stages
// of range reduction and products, 30 stages of the bit-serial square
// root, four stages forming P + d, the divisor and the nine numerators,
// FRACTION_BITS + 3 stages of the nine-lane restoring divider, a clamp
// stage and the output register.
//
// Reset clears every valid bit and the skid buffer; no result is shown
// until a new transaction enters. When the receiver stalls, the result
// holds on o_data and one more result lands in a skid register; only when
// that register is full does o_stall rise and the whole pipeline freeze.
module rotation_matrix_between_vectors import rmbv_pkg::*; #(
    parameter int FRACTION_BITS = FRAC_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    localparam int MAX_SH = CW - RW;
    localparam int SHW    = (MAX_SH > 1) ? $clog2(MAX_SH + 1) : 1;
    localparam int DVW    = SW + FRACTION_BITS;
    localparam int QB     = FRACTION_BITS + 2;
    localparam int SQSB   = $bits(t_sq_side);
    localparam int DVSB   = $bits(t_dv_side);

    // Output limits: the unit value, further bounded by the 16-bit field.
    localparam longint UNIT  = 64'(1) << FRACTION_BITS;
    localparam longint PLIM  = (UNIT > 32767) ? 32767 : UNIT;
    localparam longint NLIM  = (UNIT > 32768) ? 32768 : UNIT;
    localparam logic [QB-1:0] P_LIM  = QB'(PLIM);
    localparam logic [QB-1:0] N_LIM  = QB'(NLIM);
    localparam logic signed [OW-1:0] ONE_ID = OW'(PLIM);

    // The pipeline advances whenever the skid register has room.
    logic en;
    logic r_skid_full;
    assign en      = !r_skid_full;
    assign o_stall = r_skid_full;

    // Smallest right shift that brings all three components into RW bits.
    function automatic logic [SHW-1:0] red_shift(input logic signed [CW-1:0] x,
                                                 input logic signed [CW-1:0] y,
                                                 input logic signed [CW-1:0] z);
        logic [SHW-1:0] s;
        logic signed [CW-1:0] tx, ty, tz;
        logic fx, fy, fz;
        s = SHW'(MAX_SH);
        for (int k = MAX_SH - 1; k >= 0; k--) begin
            tx = x >>> k;
            ty = y >>> k;
            tz = z >>> k;
            fx = (tx[CW-1:RW-1] == '0) || (tx[CW-1:RW-1] == '1);
            fy = (ty[CW-1:RW-1] == '0) || (ty[CW-1:RW-1] == '1);
            fz = (tz[CW-1:RW-1] == '0) || (tz[CW-1:RW-1] == '1);
            if (fx && fy && fz) begin
                s = SHW'(k);
            end
        end
        return s;
    endfunction

    // Stage 1: zero test and range reduction.
    logic [SHW-1:0]       sh_a, sh_b;
    logic signed [RW-1:0] n1_a [3];
    logic signed [RW-1:0] n1_b [3];
    logic                 n1_zero;
    logic                 r1_v, r1_zero;
    logic signed [RW-1:0] r1_a [3];
    logic signed [RW-1:0] r1_b [3];

    always_comb begin
        sh_a    = red_shift(i_data.before_x, i_data.before_y, i_data.before_z);
        sh_b    = red_shift(i_data.after_x, i_data.after_y, i_data.after_z);
        n1_a[0] = RW'(i_data.before_x >>> sh_a);
        n1_a[1] = RW'(i_data.before_y >>> sh_a);
        n1_a[2] = RW'(i_data.before_z >>> sh_a);
        n1_b[0] = RW'(i_data.after_x >>> sh_b);
        n1_b[1] = RW'(i_data.after_y >>> sh_b);
        n1_b[2] = RW'(i_data.after_z >>> sh_b);
        n1_zero = (i_data.before_x == '0 && i_data.before_y == '0 && i_data.before_z == '0)
               || (i_data.after_x == '0 && i_data.after_y == '0 && i_data.after_z == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_zero <= n1_zero;
            for (int i = 0; i < 3; i++) begin
                r1_a[i] <= n1_a[i];
                r1_b[i] <= n1_b[i];
            end
        end
    end

    // Stage 2: squares and every a_i * b_j.
    logic                   r2_v, r2_zero;
    logic signed [2*RW-1:0] r2_aa [3];
    logic signed [2*RW-1:0] r2_bb [3];
    logic signed [2*RW-1:0] r2_ab [3][3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_zero <= r1_zero;
            for (int i = 0; i < 3; i++) begin
                r2_aa[i] <= r1_a[i] * r1_a[i];
                r2_bb[i] <= r1_b[i] * r1_b[i];
                for (int j = 0; j < 3; j++) begin
                    r2_ab[i][j] <= r1_a[i] * r1_b[j];
                end
            end
        end
    end

    // Stage 3: norms, dot product and cross product.
    logic                 r3_v, r3_zero;
    logic [NW-1:0]        r3_na, r3_nb;
    logic signed [DW-1:0] r3_d;
    logic signed [DW-1:0] r3_c [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_zero <= r2_zero;
            r3_na   <= NW'(r2_aa[0]) + NW'(r2_aa[1]) + NW'(r2_aa[2]);
            r3_nb   <= NW'(r2_bb[0]) + NW'(r2_bb[1]) + NW'(r2_bb[2]);
            r3_d    <= DW'(r2_ab[0][0]) + DW'(r2_ab[1][1]) + DW'(r2_ab[2][2]);
            r3_c[0] <= DW'(r2_ab[1][2]) - DW'(r2_ab[2][1]);
            r3_c[1] <= DW'(r2_ab[2][0]) - DW'(r2_ab[0][2]);
            r3_c[2] <= DW'(r2_ab[0][1]) - DW'(r2_ab[1][0]);
        end
    end

    // Stage 4: radicand |a|^2 |b|^2 and the products of cross components.
    logic signed [2*DW-1:0] ccp [NCC];
    t_sq_side               n4_side;
    logic                   r4_v;
    logic [XW-1:0]          r4_x;
    t_sq_side               r4_side;

    always_comb begin
        ccp[0] = r3_c[0] * r3_c[0];
        ccp[1] = r3_c[0] * r3_c[1];
        ccp[2] = r3_c[0] * r3_c[2];
        ccp[3] = r3_c[1] * r3_c[1];
        ccp[4] = r3_c[1] * r3_c[2];
        ccp[5] = r3_c[2] * r3_c[2];
        n4_side.zero = r3_zero;
        n4_side.d    = r3_d;
        for (int i = 0; i < 3; i++) begin
            n4_side.c[i] = r3_c[i];
        end
        for (int k = 0; k < NCC; k++) begin
            n4_side.cc[k] = ccp[k][CCW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_x    <= r3_na * r3_nb;
            r4_side <= n4_side;
        end
    end

    // Square root P = floor(sqrt(|a|^2 |b|^2)).
    logic             sq_v;
    logic [RTW-1:0]   sq_root;
    logic [SQSB-1:0]  sq_side_bits;
    t_sq_side         sq_side;

    rmbv_sqrt #(
        .SBW (SQSB)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_v),
        .i_x     (r4_x),
        .i_side  (r4_side),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side_bits)
    );

    assign sq_side = t_sq_side'(sq_side_bits);

    // Stage A: P + d and the antiparallel test.
    logic signed [PDW-1:0] nA_pd;
    logic                  rA_v, rA_dg;
    logic [RTW-1:0]        rA_p;
    logic signed [PDW-1:0] rA_pd;
    t_sq_side              rA_side;

    assign nA_pd = $signed({2'b00, sq_root}) + PDW'($signed(sq_side.d));

    always_ff @(posedge i_clk) begin
        if (en) begin
            rA_p    <= sq_root;
            rA_pd   <= nA_pd;
            rA_dg   <= sq_side.zero || nA_pd[PDW-1] || (nA_pd == '0);
            rA_side <= sq_side;
        end
    end

    // Stage B: divisor P * (P + d), and d and c_i scaled by P + d.
    logic                 rB_v, rB_dg;
    logic [QW-1:0]        rB_q;
    logic signed [SW-1:0] rB_pd_d;
    logic signed [SW-1:0] rB_pd_c [3];
    logic [NCC-1:0][CCW-1:0] rB_cc;

    always_ff @(posedge i_clk) begin
        if (en) begin
            rB_dg   <= rA_dg;
            rB_q    <= rA_p * rA_pd[PDW-2:0];
            rB_pd_d <= $signed(rA_side.d) * rA_pd;
            for (int i = 0; i < 3; i++) begin
                rB_pd_c[i] <= $signed(rA_side.c[i]) * rA_pd;
            end
            rB_cc <= rA_side.cc;
        end
    end

    // Stage C: numerators (d*I + K)(P + d) + c c^T, row-major.
    logic signed [SW-1:0] ccx [NCC];
    logic signed [SW-1:0] nC_s [NE];
    logic                 rC_v, rC_dg;
    logic [QW-1:0]        rC_q;
    logic signed [SW-1:0] rC_s [NE];

    always_comb begin
        for (int k = 0; k < NCC; k++) begin
            ccx[k] = SW'($signed(rB_cc[k]));
        end
        nC_s[0] = rB_pd_d    + ccx[0];
        nC_s[1] = ccx[1]     - rB_pd_c[2];
        nC_s[2] = rB_pd_c[1] + ccx[2];
        nC_s[3] = rB_pd_c[2] + ccx[1];
        nC_s[4] = rB_pd_d    + ccx[3];
        nC_s[5] = ccx[4]     - rB_pd_c[0];
        nC_s[6] = ccx[2]     - rB_pd_c[1];
        nC_s[7] = rB_pd_c[0] + ccx[4];
        nC_s[8] = rB_pd_d    + ccx[5];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rC_dg <= rB_dg;
            rC_q  <= rB_q;
            for (int l = 0; l < NE; l++) begin
                rC_s[l] <= nC_s[l];
            end
        end
    end

    // Stage D: magnitude scaled by 2^F, plus half the divisor for rounding.
    logic signed [SW-1:0] mag_s [NE];
    logic [DVW-1:0]       nD_num [NE];
    t_dv_side             nD_side;
    logic                 rD_v;
    logic [QW-1:0]        rD_q;
    logic [DVW-1:0]       rD_num [NE];
    t_dv_side             rD_side;

    always_comb begin
        nD_side.dg = rC_dg;
        for (int l = 0; l < NE; l++) begin
            nD_side.neg[l] = rC_s[l][SW-1];
            mag_s[l]       = rC_s[l][SW-1] ? -rC_s[l] : rC_s[l];
            nD_num[l]      = {1'b0, mag_s[l][SW-2:0], {FRACTION_BITS{1'b0}}}
                           + DVW'(rC_q >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rD_q    <= rC_q;
            rD_side <= nD_side;
            for (int l = 0; l < NE; l++) begin
                rD_num[l] <= nD_num[l];
            end
        end
    end

    // Nine-lane restoring divider.
    logic             dv_v;
    logic [QB-1:0]    dv_quo [NE];
    logic             dv_big [NE];
    logic [DVSB-1:0]  dv_side_bits;
    t_dv_side         dv_side;

    rmbv_div #(
        .FRAC (FRACTION_BITS),
        .SBW  (DVSB)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (rD_v),
        .i_num   (rD_num),
        .i_q     (rD_q),
        .i_side  (rD_side),
        .o_valid (dv_v),
        .o_quo   (dv_quo),
        .o_big   (dv_big),
        .o_side  (dv_side_bits)
    );

    assign dv_side = t_dv_side'(dv_side_bits);

    // Stage E: sign, saturation and the identity override.
    logic [QB-1:0]        lim  [NE];
    logic [QB-1:0]        mag  [NE];
    logic signed [OW-1:0] ent  [NE];
    t_out                 nE_data;
    logic                 rE_v;
    t_out                 rE_data;

    always_comb begin
        for (int l = 0; l < NE; l++) begin
            lim[l] = dv_side.neg[l] ? N_LIM : P_LIM;
            mag[l] = (dv_big[l] || dv_quo[l] > lim[l]) ? lim[l] : dv_quo[l];
            if (dv_side.dg) begin
                ent[l] = (l % 4 == 0) ? ONE_ID : '0;
            end else if (dv_side.neg[l]) begin
                ent[l] = -OW'(mag[l]);
            end else begin
                ent[l] = OW'(mag[l]);
            end
        end
        nE_data.m00        = ent[0];
        nE_data.m01        = ent[1];
        nE_data.m02        = ent[2];
        nE_data.m10        = ent[3];
        nE_data.m11        = ent[4];
        nE_data.m12        = ent[5];
        nE_data.m20        = ent[6];
        nE_data.m21        = ent[7];
        nE_data.m22        = ent[8];
        nE_data.degenerate = dv_side.dg;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rE_data <= nE_data;
        end
    end

    // Valid bits of the stages in this module.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            rA_v <= 1'b0;
            rB_v <= 1'b0;
            rC_v <= 1'b0;
            rD_v <= 1'b0;
            rE_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            rA_v <= sq_v;
            rB_v <= rA_v;
            rC_v <= rB_v;
            rD_v <= rC_v;
            rE_v <= dv_v;
        end
    end

    // Output register with one skid entry. A result leaves stage E whenever
    // the pipeline moves; it goes to the output register if that is free or
    // being taken, otherwise to the skid register.
    logic r_out_v;
    t_out r_out;
    t_out r_skid;
    logic out_take;

    assign out_take = r_out_v && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v     <= 1'b0;
            r_skid_full <= 1'b0;
        end else if (r_skid_full) begin
            if (out_take) begin
                r_skid_full <= 1'b0;
            end
        end else if (rE_v) begin
            if (r_out_v && i_stall) begin
                r_skid_full <= 1'b1;
            end else begin
                r_out_v <= 1'b1;
            end
        end else if (out_take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_full) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (rE_v) begin
            if (r_out_v && i_stall) begin
                r_skid <= rE_data;
            end else begin
                r_out <= rE_data;
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

// ===== sv/rmbv_check.sv =====
`include "assert_macros.svh"

module rmbv_check import rmbv_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input t_out o_data
);

    logic ident;

    // A degenerate result must be an identity matrix with a nonzero diagonal.
    assign ident = (o_data.m01 == '0) && (o_data.m02 == '0) && (o_data.m10 == '0)
                && (o_data.m12 == '0) && (o_data.m20 == '0) && (o_data.m21 == '0)
                && (o_data.m00 == o_data.m11) && (o_data.m11 == o_data.m22)
                && (o_data.m00 != '0);

    `ASSERT_CLK_RST(a_out_hold, o_valid && i_stall |=> o_valid, "result dropped while stalled")
    `ASSERT_CLK_RST(a_out_stable, o_valid && i_stall |=> $stable(o_data), "stalled result changed")
    `ASSERT_CLK_RST(a_degen_ident, o_valid && o_data.degenerate |-> ident, "degenerate not identity")
    `ASSERT_CLK(a_reset_clear, !i_rst_n |=> !o_valid && !o_stall, "reset did not clear outputs")

endmodule

bind rotation_matrix_between_vectors rmbv_check u_rmbv_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
